[rtl/crab_pkg.sv]
// shared types, codes and constants for the clipped rectangle alpha blend block
// used by crab_blend and clipped_rect_alpha_blend; no dependencies
package crab_pkg;

   // field and datapath widths
   localparam int COORD_W    = 13;
   localparam int DIM_W      = 8;
   localparam int IDX_W      = 16;
   localparam int CHAN_W     = 8;
   localparam int PIXEL_W    = 32;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 88;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [CHAN_W-1:0]  chan_type;

   // command codes
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RECT  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLIPPED = 2'd2;

   // register select, taken from address bit 2
   localparam logic CSR_SEL_WIDTH  = 1'b0;
   localparam logic CSR_SEL_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] DIM_RESET    = 8'd128;
   localparam chan_type          ALPHA_OPAQUE = 8'hFF;

   // floor(v / 255) for any v below 65280, by reciprocal with correction
   function automatic chan_type div255(input logic [IDX_W-1:0] v);
      logic [IDX_W:0] t;
      t = {1'b0, v} + 17'd1 + 17'(v >> CHAN_W);
      return t[IDX_W-1:CHAN_W];
   endfunction

endpackage

[rtl/clipped_rect_alpha_blend.sv]
// rectangle: walk issues one store read a cycle
// throughput: one command at a time; the next is taken while a result waits on rsp
// reset clears control, sets both surface dimensions to 128; frame store is not cleared
// top level: framebuffer store, command sequencer, csr port; depends on crab_pkg, crab_blend
module clipped_rect_alpha_blend #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // x_start[12:0], x_end[25:13], y_start[38:26], y_end[51:39], color[83:52], zeros
   input  logic [crab_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd[1:0]
   input  logic [crab_pkg::CMD_W-1:0]        req_tuser,
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixel_value[31:0]
   output logic [crab_pkg::PIXEL_W-1:0]      rsp_tdata,
   // status[1:0]
   output logic [crab_pkg::STATUS_W-1:0]     rsp_tuser,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [crab_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [crab_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [crab_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import crab_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_PIXEL,
      ST_RDWAIT,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [DIM_W-1:0] width_ff, height_ff;
   logic [DIM_W-1:0] eff_w, eff_h;
   logic             csr_wr;

   // latched command
   logic [CMD_W-1:0]   cmd_ff;
   logic [COORD_W-1:0] xs_ff, xe_ff, ys_ff, ye_ff;
   pixel_type          color_ff;

   // walk counters
   logic [DIM_W-1:0] x_ff, x0_ff, x1_ff, y_ff, y1_ff;
   logic [IDX_W-1:0] row_base_ff;
   logic             x_last, y_last;

   // result holding and output register
   logic [STATUS_W-1:0] res_status_ff;
   pixel_type           res_pixel_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   pixel_type           rsp_pixel_ff;
   logic                rsp_free;

   // setup decode
   logic signed [COORD_W:0] xs_s, xe_s, ys_s, ye_s, w_s, h_s;
   logic signed [COORD_W:0] cxs, cxe, cys, cye;
   logic                    pix_in_range, rect_empty, is_rect;
   logic [DIM_W-1:0]        sel_x, sel_y;
   logic [IDX_W-1:0]        row_mult;

   // store and blend pipeline
   pixel_type        mem [DEPTH];
   logic [ADDR_W-1:0] cur_addr, wr_addr;
   pixel_type        wr_data, rd_data_ff, blend_out;
   logic             wr_en;
   logic             p1_vld_ff, p2_vld_ff;
   logic [ADDR_W-1:0] p1_addr_ff, p2_addr_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_SEL_HEIGHT) ? CSR_DATA_W'(height_ff)
                                                         : CSR_DATA_W'(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_SEL_HEIGHT) begin
            height_ff <= csr_pwdata[DIM_W-1:0];
         end else begin
            width_ff <= csr_pwdata[DIM_W-1:0];
         end
      end
   end

   // effective surface size, saturated to 1..max
   always_comb begin
      if (width_ff == '0) begin
         eff_w = DIM_W'(1);
      end else if (13'(width_ff) > 13'(MAX_WIDTH)) begin
         eff_w = DIM_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = DIM_W'(1);
      end else if (13'(height_ff) > 13'(MAX_HEIGHT)) begin
         eff_h = DIM_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   // range check and clipping of the latched command
   assign xs_s = {xs_ff[COORD_W-1], xs_ff};
   assign xe_s = {xe_ff[COORD_W-1], xe_ff};
   assign ys_s = {ys_ff[COORD_W-1], ys_ff};
   assign ye_s = {ye_ff[COORD_W-1], ye_ff};
   assign w_s  = {6'b0, eff_w};
   assign h_s  = {6'b0, eff_h};

   assign pix_in_range = (xs_s >= 0) && (xs_s < w_s) && (ys_s >= 0) && (ys_s < h_s);

   assign cxs = (xs_s < 0) ? '0 : xs_s;
   assign cys = (ys_s < 0) ? '0 : ys_s;
   assign cxe = (xe_s > w_s) ? w_s : xe_s;
   assign cye = (ye_s > h_s) ? h_s : ye_s;

   assign rect_empty = (cxs >= cxe) || (cys >= cye);
   assign is_rect    = (cmd_ff == CMD_RECT);
   assign sel_x      = is_rect ? cxs[DIM_W-1:0] : xs_ff[DIM_W-1:0];
   assign sel_y      = is_rect ? cys[DIM_W-1:0] : ys_ff[DIM_W-1:0];
   assign row_mult   = IDX_W'(sel_y) * IDX_W'(eff_w);

   // walk position
   assign x_last   = ((x_ff + 8'd1) == x1_ff);
   assign y_last   = ((y_ff + 8'd1) == y1_ff);
   assign cur_addr = ADDR_W'(row_base_ff + IDX_W'(x_ff));
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            case (cmd_ff)
               CMD_WRITE, CMD_READ: state_in = pix_in_range ? ST_PIXEL : ST_DONE;
               CMD_RECT:            state_in = rect_empty ? ST_DONE : ST_WALK;
               default:             state_in = ST_DONE;
            endcase
         end
         ST_PIXEL:  state_in = (cmd_ff == CMD_READ) ? ST_RDWAIT : ST_DONE;
         ST_RDWAIT: state_in = ST_DONE;
         ST_WALK: begin
            if (x_last && y_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!p1_vld_ff && !p2_vld_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_pixel_ff  <= res_pixel_ff;
      end
   end

   // command capture, walk counters and result
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff   <= req_tuser;
         xs_ff    <= req_tdata[12:0];
         xe_ff    <= req_tdata[25:13];
         ys_ff    <= req_tdata[38:26];
         ye_ff    <= req_tdata[51:39];
         color_ff <= req_tdata[83:52];
      end
      case (state_ff)
         ST_SETUP: begin
            x_ff         <= sel_x;
            x0_ff        <= sel_x;
            x1_ff        <= cxe[DIM_W-1:0];
            y_ff         <= sel_y;
            y1_ff        <= cye[DIM_W-1:0];
            row_base_ff  <= row_mult;
            res_pixel_ff <= '0;
            case (cmd_ff)
               CMD_WRITE, CMD_READ: begin
                  res_status_ff <= pix_in_range ? STATUS_DONE : STATUS_RANGE;
               end
               CMD_RECT: res_status_ff <= rect_empty ? STATUS_CLIPPED : STATUS_DONE;
               default:  res_status_ff <= STATUS_DONE;
            endcase
         end
         ST_RDWAIT: res_pixel_ff <= rd_data_ff;
         ST_WALK: begin
            if (x_last) begin
               x_ff        <= x0_ff;
               y_ff        <= y_ff + 8'd1;
               row_base_ff <= row_base_ff + IDX_W'(eff_w);
            end else begin
               x_ff <= x_ff + 8'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // blend pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= (state_ff == ST_WALK);
         p2_vld_ff <= p1_vld_ff;
      end
      p1_addr_ff <= cur_addr;
      p2_addr_ff <= p1_addr_ff;
   end

   crab_blend u_blend (
      .clock   (clock),
      .fg      (color_ff),
      .bg      (rd_data_ff),
      .blended (blend_out)
   );

   // store write: blend write-back or a pixel write, never both in one cycle
   assign wr_en   = p2_vld_ff || (state_ff == ST_PIXEL && cmd_ff == CMD_WRITE);
   assign wr_addr = p2_vld_ff ? p2_addr_ff : cur_addr;
   assign wr_data = p2_vld_ff ? blend_out : color_ff;

   // frame store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[cur_addr];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tuser  = rsp_status_ff;

   // walk stays inside the clipped span
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> (x_ff < x1_ff) && (y_ff < y1_ff))
      else $error("walk position outside clipped span");

   // a new command is only taken once the blend pipeline is empty
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !p1_vld_ff && !p2_vld_ff)
      else $error("command taken with blend write-back pending");

   // every issued read reaches the write-back stage
   assert property (@(posedge clock) disable iff (reset)
      p1_vld_ff |=> p2_vld_ff)
      else $error("blend pipeline lost a pixel");

   // write-back only happens during a rectangle
   assert property (@(posedge clock) disable iff (reset)
      p2_vld_ff |-> (state_ff == ST_WALK) || (state_ff == ST_DRAIN))
      else $error("write-back outside rectangle walk");

endmodule

[rtl/crab_blend.sv]
// two stage alpha blend of a colour word over a stored pixel word
// stage one registers the channel products, stage two sums and divides by 255
// depends on crab_pkg
module crab_blend (
   input  logic                clock,
   input  crab_pkg::pixel_type fg,
   input  crab_pkg::pixel_type bg,
   output crab_pkg::pixel_type blended
);
   import crab_pkg::*;

   chan_type alpha;
   chan_type inv_alpha;
   chan_type chan_out [3];

   assign alpha     = fg[PIXEL_W-1 -: CHAN_W];
   assign inv_alpha = ALPHA_OPAQUE - alpha;

   // one lane per colour channel, blue lowest
   for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [IDX_W-1:0] fg_prod_in;
      logic [IDX_W-1:0] bg_prod_in;
      logic [IDX_W-1:0] fg_prod_ff;
      logic [IDX_W-1:0] bg_prod_ff;

      assign fg_prod_in = IDX_W'(fg[c*CHAN_W +: CHAN_W]) * IDX_W'(alpha);
      assign bg_prod_in = IDX_W'(bg[c*CHAN_W +: CHAN_W]) * IDX_W'(inv_alpha);

      always_ff @(posedge clock) begin
         fg_prod_ff <= fg_prod_in;
         bg_prod_ff <= bg_prod_in;
      end

      // sum stays below 65026, so 16 bits hold it
      assign chan_out[c] = div255(fg_prod_ff + bg_prod_ff);
   end

   assign blended = {ALPHA_OPAQUE, chan_out[2], chan_out[1], chan_out[0]};

endmodule

[bench/frame_blend_checker.sv]
// checker for the clipped rectangle alpha blend block: follows csr, req and rsp transfers,
// keeps its own copy of the frame store and compares every reply; depends on crab_pkg
module frame_blend_checker #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // x_start[12:0], x_end[25:13], y_start[38:26], y_end[51:39], color[83:52], zeros
   input  logic [crab_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd[1:0]
   input  logic [crab_pkg::CMD_W-1:0]        req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixel_value[31:0]
   input  logic [crab_pkg::PIXEL_W-1:0]      rsp_tdata,
   // status[1:0]
   input  logic [crab_pkg::STATUS_W-1:0]     rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [crab_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [crab_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic [crab_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  logic                              csr_pready,
   output int                                mismatch_count,
   output int                                awaited_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import crab_pkg::*;

   typedef struct packed {
      pixel_type                pixel;
      logic [STATUS_W-1:0]      status;
   } reply_type;

   pixel_type         shadow_frame [MAX_WIDTH*MAX_HEIGHT];
   logic [DIM_W-1:0]  shadow_width;
   logic [DIM_W-1:0]  shadow_height;
   reply_type         awaited_replies [$];
   int                reply_index;

   // register value saturated to the usable surface size
   function automatic int fit_dim(logic [DIM_W-1:0] reg_value, int limit);
      if (reg_value == '0)
         return 1;
      if (int'(reg_value) > limit)
         return limit;
      return int'(reg_value);
   endfunction

   // colour over stored pixel, per channel floor of the weighted sum over 255
   function automatic pixel_type mix_over(pixel_type fg, pixel_type bg);
      pixel_type mixed;
      int        alpha;
      alpha = int'(fg[31:24]);
      mixed[31:24] = ALPHA_OPAQUE;
      for (int c = 0; c < 3; c++) begin
         mixed[CHAN_W*c +: CHAN_W] = chan_type'((int'(fg[CHAN_W*c +: CHAN_W]) * alpha
            + int'(bg[CHAN_W*c +: CHAN_W]) * (255 - alpha)) / 255);
      end
      return mixed;
   endfunction

   // carries out one command on the shadow store and gives the reply it must cause
   function automatic reply_type apply_command(logic [CMD_W-1:0] op, int xs, int xe, int ys,
                                               int ye, pixel_type colour);
      reply_type reply;
      int        w;
      int        h;
      int        idx;
      reply.pixel  = '0;
      reply.status = STATUS_DONE;
      w = fit_dim(shadow_width, MAX_WIDTH);
      h = fit_dim(shadow_height, MAX_HEIGHT);
      case (op)
         CMD_WRITE, CMD_READ: begin
            if (xs < 0 || xs >= w || ys < 0 || ys >= h) begin
               reply.status = STATUS_RANGE;
            end else begin
               idx = xs + ys * w;
               if (op == CMD_WRITE)
                  shadow_frame[idx] = colour;
               else
                  reply.pixel = shadow_frame[idx];
            end
         end
         CMD_RECT: begin
            if (xs < 0) xs = 0;
            if (ys < 0) ys = 0;
            if (xe > w) xe = w;
            if (ye > h) ye = h;
            if (xs >= xe || ys >= ye) begin
               reply.status = STATUS_CLIPPED;
            end else begin
               for (int y = ys; y < ye; y++)
                  for (int x = xs; x < xe; x++)
                     shadow_frame[x + y * w] = mix_over(colour, shadow_frame[x + y * w]);
            end
         end
         default: ;
      endcase
      return reply;
   endfunction

   always @(posedge clock) begin
      reply_type        want;
      logic [DIM_W-1:0] held;
      if (reset) begin
         shadow_width   = DIM_RESET;
         shadow_height  = DIM_RESET;
         mismatch_count = 0;
         awaited_count  = 0;
         reply_index    = 0;
         awaited_replies.delete();
      end else begin
         // register writes update the mirror, reads are checked against it
         if (csr_psel && csr_penable && csr_pready) begin
            held = (csr_paddr[2] == CSR_SEL_WIDTH) ? shadow_width : shadow_height;
            if (csr_pwrite) begin
               if (csr_paddr[2] == CSR_SEL_WIDTH)
                  shadow_width = csr_pwdata[DIM_W-1:0];
               else
                  shadow_height = csr_pwdata[DIM_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(held)) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("csr read at %0h: expected %h got %h", csr_paddr,
                           CSR_DATA_W'(held), csr_prdata);
            end
         end

         // reply transfer against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected reply: pixel %h status %0d", rsp_tdata, rsp_tuser);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_tdata !== want.pixel || rsp_tuser !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("reply %0d: pixel expected %h got %h, status expected %0d got %0d",
                              reply_index, want.pixel, rsp_tdata, want.status, rsp_tuser);
               end
            end
            reply_index++;
         end

         // command transfer
         if (req_tvalid && req_tready)
            awaited_replies.push_back(apply_command(req_tuser,
               $signed(req_tdata[12:0]), $signed(req_tdata[25:13]),
               $signed(req_tdata[38:26]), $signed(req_tdata[51:39]), req_tdata[83:52]));

         awaited_count = awaited_replies.size();
      end
   end

endmodule

[bench/tb_top.sv]
// testbench top for clipped_rect_alpha_blend: clock, reset, command and csr stimulus,
// reply back-pressure and the verdict; depends on crab_pkg and frame_blend_checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import crab_pkg::*;

   localparam int FRAME_W     = 128;
   localparam int FRAME_H     = 128;
   localparam int AREA_CAP    = 128;
   localparam int CYCLE_LIMIT = 1000000;

   localparam logic [CMD_W-1:0]      CMD_SPARE   = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] WIDTH_ADDR  = {CSR_SEL_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] HEIGHT_ADDR = {CSR_SEL_HEIGHT, 2'b00};

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic [CMD_W-1:0]        req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [PIXEL_W-1:0]      rsp_tdata;
   logic [STATUS_W-1:0]     rsp_tuser;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int mismatch_count;
   int awaited_count;

   // stimulus bookkeeping
   bit written [FRAME_W*FRAME_H];
   int surf_w    = FRAME_W;
   int surf_h    = FRAME_H;
   int sent_count = 0;
   int rsp_count  = 0;
   int gap_pct    = 20;
   int stall_pct  = 8;
   bit calm       = 1'b0;

   clipped_rect_alpha_blend #(
      .MAX_WIDTH  (FRAME_W),
      .MAX_HEIGHT (FRAME_H)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frame_blend_checker #(
      .MAX_WIDTH  (FRAME_W),
      .MAX_HEIGHT (FRAME_H)
   ) frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // replies seen on the rsp side, used to tell when the block is idle
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         rsp_count <= rsp_count + 1;
   end

   // reply back-pressure in random bursts
   initial begin : rsp_side
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int any_coord();
      return int'($urandom_range(0, 8191)) - 4096;
   endfunction

   // a coordinate that lies off a surface of the given size
   function automatic int off_surface(int limit);
      case ($urandom_range(0, 5))
         0: return -1;
         1: return limit;
         2: return -4096;
         3: return 4095;
         4: return int'($urandom_range(limit, 4095));
         default: return -int'($urandom_range(1, 4096));
      endcase
   endfunction

   // random colour with fully clear and fully opaque alpha favoured
   function automatic pixel_type pick_colour();
      pixel_type colour;
      colour = $urandom;
      case ($urandom_range(0, 3))
         0: colour[31:24] = 8'h00;
         1: colour[31:24] = 8'hFF;
         default: ;
      endcase
      return colour;
   endfunction

   // one command transfer, with an optional gap before it
   task automatic send(input logic [CMD_W-1:0] op, input int xs, input int xe, input int ys,
                       input int ye, input pixel_type colour);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, colour, 13'(ye), 13'(ys), 13'(xe), 13'(xs)};
      do @(posedge clock); while (!req_tready);
      sent_count++;
      if (op == CMD_WRITE && xs >= 0 && xs < surf_w && ys >= 0 && ys < surf_h)
         written[xs + ys * surf_w] = 1'b1;
   endtask

   // hold off until every reply has come back
   task automatic drain();
      if (rsp_count != sent_count) begin
         req_tvalid <= 1'b0;
         while (rsp_count != sent_count) @(posedge clock);
      end
   endtask

   task automatic csr_access(input logic write_en, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [DIM_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom;
      data[DIM_W-1:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // rectangle near the surface or anywhere, with unwritten pixels under it written first
   task automatic blend_rect();
      int x0, x1, y0, y1;
      int cx0, cx1, cy0, cy1;
      if ($urandom_range(0, 3) == 0) begin
         x0 = any_coord();
         x1 = any_coord();
         y0 = any_coord();
         y1 = any_coord();
      end else begin
         x0 = int'($urandom_range(0, surf_w + 1)) - 2;
         x1 = x0 + int'($urandom_range(0, 8)) - 1;
         y0 = int'($urandom_range(0, surf_h + 1)) - 2;
         y1 = y0 + int'($urandom_range(0, 8)) - 1;
      end
      cx0 = (x0 < 0) ? 0 : x0;
      cx1 = (x1 > surf_w) ? surf_w : x1;
      cy0 = (y0 < 0) ? 0 : y0;
      cy1 = (y1 > surf_h) ? surf_h : y1;
      // a big clipped span shrinks to its top row
      if (cx0 < cx1 && cy0 < cy1 && (cx1 - cx0) * (cy1 - cy0) > AREA_CAP) begin
         y1  = cy0 + 1;
         cy1 = y1;
      end
      for (int y = cy0; y < cy1; y++)
         for (int x = cx0; x < cx1; x++)
            if (!written[x + y * surf_w])
               send(CMD_WRITE, x, any_coord(), y, any_coord(), pick_colour());
      send(CMD_RECT, x0, x1, y0, y1, pick_colour());
   endtask

   task automatic random_action();
      int pick, x, y;
      pick = $urandom_range(0, 99);
      x = $urandom_range(0, surf_w - 1);
      y = $urandom_range(0, surf_h - 1);
      // some pixel commands go off the surface
      if (pick < 60 && $urandom_range(0, 4) == 0) begin
         if ($urandom_range(0, 1)) begin
            x = off_surface(surf_w);
            y = any_coord();
         end else begin
            x = any_coord();
            y = off_surface(surf_h);
         end
      end
      if (pick < 2) begin
         drain();
      end else if (pick < 32) begin
         send(CMD_WRITE, x, any_coord(), y, any_coord(), pick_colour());
      end else if (pick < 60) begin
         if (x >= 0 && x < surf_w && y >= 0 && y < surf_h && !written[x + y * surf_w])
            send(CMD_WRITE, x, any_coord(), y, any_coord(), pick_colour());
         send(CMD_READ, x, any_coord(), y, any_coord(), $urandom);
      end else if (pick < 95) begin
         blend_rect();
      end else begin
         send(CMD_SPARE, any_coord(), any_coord(), any_coord(), any_coord(), $urandom);
      end
   endtask

   // new surface size once idle, then random traffic
   task automatic run_phase(input logic [DIM_W-1:0] width_value,
                            input logic [DIM_W-1:0] height_value, input int quota);
      int first;
      drain();
      csr_access(1'b1, WIDTH_ADDR, width_value);
      csr_access(1'b1, HEIGHT_ADDR, height_value);
      csr_access(1'b0, WIDTH_ADDR, '0);
      csr_access(1'b0, HEIGHT_ADDR, '0);
      surf_w = (width_value == '0) ? 1 : (width_value > FRAME_W) ? FRAME_W : width_value;
      surf_h = (height_value == '0) ? 1 : (height_value > FRAME_H) ? FRAME_H : height_value;
      gap_pct   = 10 * $urandom_range(0, 3);
      stall_pct = 5 * $urandom_range(0, 3);
      first = sent_count;
      while (sent_count - first < quota)
         random_action();
   endtask

   initial begin : stimulus
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_WRITE;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners, off-surface pixels, clipped spans, alpha extremes, spare command
      send(CMD_WRITE, 0, 0, 0, 0, 32'h12345678);
      send(CMD_WRITE, 127, 0, 127, 0, 32'hFFFFFFFF);
      send(CMD_WRITE, 127, 0, 0, 0, 32'h00000000);
      send(CMD_WRITE, 0, 0, 127, 0, 32'h00FF00FF);
      send(CMD_READ, 0, 0, 0, 0, '0);
      send(CMD_READ, 127, 0, 127, 0, '0);
      send(CMD_WRITE, 128, 0, 0, 0, 32'hDEADBEEF);
      send(CMD_WRITE, 0, 0, -1, 0, 32'hDEADBEEF);
      send(CMD_WRITE, -4096, 0, 4095, 0, 32'hDEADBEEF);
      send(CMD_READ, 4095, 0, 0, 0, '0);
      send(CMD_READ, 0, 0, 128, 0, '0);
      send(CMD_RECT, 128, 4095, 0, 4, 32'hFF00FF00);
      send(CMD_RECT, 5, 5, 0, 1, 32'hFF00FF00);
      send(CMD_RECT, 10, 3, 0, 1, 32'hFF00FF00);
      send(CMD_RECT, -4096, 1, -4096, 1, 32'h00ABCDEF);
      send(CMD_RECT, 127, 4095, 127, 4095, 32'hFF102030);
      send(CMD_RECT, 127, 128, 0, 1, 32'h7FFF8001);
      send(CMD_READ, 0, 0, 0, 0, '0);
      send(CMD_READ, 127, 0, 127, 0, '0);
      send(CMD_READ, 127, 0, 0, 0, '0);
      send(CMD_SPARE, -1, -1, -1, -1, 32'hFFFFFFFF);
      send(CMD_SPARE, 0, 0, 0, 0, '0);

      // random traffic over a range of surface sizes, extremes and saturation included
      run_phase(8'd128, 8'd128, 70);
      run_phase(8'd1, 8'd1, 30);
      run_phase(8'd128, 8'd1, 60);
      run_phase(8'd1, 8'd128, 60);
      run_phase(8'd0, 8'd255, 40);
      run_phase(8'd255, 8'd0, 40);
      run_phase(8'd9, 8'd6, 80);
      run_phase(DIM_W'($urandom_range(1, 16)), DIM_W'($urandom_range(1, 16)), 60);
      run_phase(DIM_W'($urandom), DIM_W'($urandom), 50);
      calm = 1'b1;
      run_phase(8'd128, 8'd128, 60);

      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && awaited_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[clipped_rect_alpha_blend.f]
rtl/crab_pkg.sv
rtl/crab_blend.sv
rtl/clipped_rect_alpha_blend.sv
bench/frame_blend_checker.sv
bench/tb_top.sv
